// ===== rtl/bldcdr_pkg.sv =====
// ----------------------------------------------------------------------------
// bldcdr_pkg
// Shared types, register indexes and commutation tables for the two-axis
// duty ramp and six-step commutation block.
// ----------------------------------------------------------------------------
package bldcdr_pkg;

  localparam int CfgW    = 15;
  localparam int CfgIdxW = 2;
  localparam int HallW   = 3;
  localparam int MaskW   = 6;

  // tick item layout on the input tdata bus, padded to whole bytes
  localparam int InBits  = CfgW + 1 + HallW;
  localparam int InW     = ((InBits + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_DUTY  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_DUTY  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_RAMP_STEP = 2'd2;

  localparam logic [CfgW-1:0] MIN_DUTY_RST  = 15'd0;
  localparam logic [CfgW-1:0] MAX_DUTY_RST  = 15'd32767;
  localparam logic [CfgW-1:0] RAMP_STEP_RST = 15'd1;

  // hall codes with all sensors equal are not valid rotor positions
  localparam logic [HallW-1:0] HALL_ALL_LOW  = 3'h0;
  localparam logic [HallW-1:0] HALL_ALL_HIGH = 3'h7;

  // commutation table words
  localparam logic [MaskW-1:0] MASK_ALL  = 6'h3F;
  localparam logic [MaskW-1:0] MASK_0F   = 6'h0F;
  localparam logic [MaskW-1:0] MASK_33   = 6'h33;
  localparam logic [MaskW-1:0] MASK_3C   = 6'h3C;
  localparam logic [MaskW-1:0] CTRL_02   = 6'h02;
  localparam logic [MaskW-1:0] CTRL_20   = 6'h20;
  localparam logic [MaskW-1:0] CTRL_08   = 6'h08;
  localparam logic [MaskW-1:0] CTRL_NONE = 6'h00;

  typedef struct packed {
    logic [CfgW-1:0] duty_floor;
    logic [CfgW-1:0] duty_ceil;
    logic [CfgW-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic             axis;
    logic [CfgW-1:0]  req_duty;
    logic             req_dir;
    logic [HallW-1:0] hall_code;
  } tick_t;

  typedef struct packed {
    logic             dir;
    logic             flip;
    logic             fault;
    logic [MaskW-1:0] channel_mask;
    logic [MaskW-1:0] output_control;
  } res_t;

  function automatic logic [MaskW-1:0] fwd_mask(input logic [HallW-1:0] h);
    logic [MaskW-1:0] m;
    case (h)
      3'd1:    m = MASK_0F;
      3'd2:    m = MASK_33;
      3'd3:    m = MASK_33;
      3'd4:    m = MASK_3C;
      3'd5:    m = MASK_0F;
      3'd6:    m = MASK_3C;
      default: m = MASK_ALL;
    endcase
    return m;
  endfunction

  function automatic logic [MaskW-1:0] fwd_ctrl(input logic [HallW-1:0] h);
    logic [MaskW-1:0] c;
    case (h)
      3'd1:    c = CTRL_02;
      3'd2:    c = CTRL_20;
      3'd3:    c = CTRL_02;
      3'd4:    c = CTRL_08;
      3'd5:    c = CTRL_08;
      3'd6:    c = CTRL_20;
      default: c = CTRL_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [MaskW-1:0] inv_mask(input logic [HallW-1:0] h);
    logic [MaskW-1:0] m;
    case (h)
      3'd1:    m = MASK_3C;
      3'd2:    m = MASK_0F;
      3'd3:    m = MASK_3C;
      3'd4:    m = MASK_33;
      3'd5:    m = MASK_33;
      3'd6:    m = MASK_0F;
      default: m = MASK_ALL;
    endcase
    return m;
  endfunction

  function automatic logic [MaskW-1:0] inv_ctrl(input logic [HallW-1:0] h);
    logic [MaskW-1:0] c;
    case (h)
      3'd1:    c = CTRL_20;
      3'd2:    c = CTRL_08;
      3'd3:    c = CTRL_08;
      3'd4:    c = CTRL_02;
      3'd5:    c = CTRL_20;
      3'd6:    c = CTRL_02;
      default: c = CTRL_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bldcdr_core.sv =====
// ----------------------------------------------------------------------------
// bldcdr_core
// Next-state logic for one tick: request clamp, duty slew, reversal and
// commutation table lookup.
// ----------------------------------------------------------------------------
module bldcdr_core #(
  parameter int DUTY_BITS = 16
) (
  input  logic signed [DUTY_BITS-1:0] cur_duty_i,
  input  logic                        cur_dir_i,
  input  logic                        cur_fault_i,
  input  bldcdr_pkg::tick_t           tick_i,
  input  bldcdr_pkg::cfg_t            cfg_i,
  output logic signed [DUTY_BITS-1:0] new_duty_o,
  output bldcdr_pkg::res_t            res_o
);

  // wide enough for the duty range, the 15-bit registers and one add
  localparam int CW = ((DUTY_BITS > 16) ? DUTY_BITS : 16) + 2;
  localparam logic signed [CW-1:0] DutyHi =
    {{(CW-DUTY_BITS+1){1'b0}}, {(DUTY_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] DutyLo = ~DutyHi;

  logic signed [CW-1:0] d_w, min_w, max_w, step_w, req_w;
  logic signed [CW-1:0] req_c, dn_w, t_w, lim_w;
  logic                 flip, new_dir, hall_bad;

  assign d_w    = {{(CW-DUTY_BITS){cur_duty_i[DUTY_BITS-1]}}, cur_duty_i};
  assign min_w  = {{(CW-bldcdr_pkg::CfgW){1'b0}}, cfg_i.duty_floor};
  assign max_w  = {{(CW-bldcdr_pkg::CfgW){1'b0}}, cfg_i.duty_ceil};
  assign step_w = {{(CW-bldcdr_pkg::CfgW){1'b0}}, cfg_i.ramp_step};
  assign req_w  = {{(CW-bldcdr_pkg::CfgW){1'b0}}, tick_i.req_duty};
  assign dn_w   = d_w - step_w;

  always_comb begin
    // max wins when min is above max
    req_c = req_w;
    if (req_c < min_w) req_c = min_w;
    if (req_c > max_w) req_c = max_w;

    flip = 1'b0;
    if (tick_i.req_dir != cur_dir_i) begin
      if (dn_w < min_w) begin
        flip = 1'b1;
        if (dn_w < -min_w) begin
          // overshoot past the floor carries over into the new direction
          t_w = -dn_w;
          if (t_w > req_c) t_w = req_c;
        end else begin
          t_w = min_w;
        end
      end else begin
        t_w = dn_w;
      end
    end else if (req_c > d_w) begin
      t_w = (req_c - d_w >= step_w) ? d_w + step_w : req_c;
    end else if (req_c < d_w) begin
      t_w = (d_w - req_c >= step_w) ? dn_w : req_c;
    end else begin
      t_w = d_w;
    end

    lim_w = t_w;
    if (t_w > DutyHi) lim_w = DutyHi;
    if (t_w < DutyLo) lim_w = DutyLo;
  end

  assign new_duty_o = lim_w[DUTY_BITS-1:0];
  assign new_dir    = flip ? tick_i.req_dir : cur_dir_i;
  assign hall_bad   = tick_i.hall_code inside {bldcdr_pkg::HALL_ALL_LOW,
                                               bldcdr_pkg::HALL_ALL_HIGH};

  always_comb begin
    res_o.dir   = new_dir;
    res_o.flip  = flip;
    res_o.fault = cur_fault_i | hall_bad;
    if (new_dir) begin
      res_o.channel_mask   = bldcdr_pkg::inv_mask(tick_i.hall_code);
      res_o.output_control = bldcdr_pkg::inv_ctrl(tick_i.hall_code);
    end else begin
      res_o.channel_mask   = bldcdr_pkg::fwd_mask(tick_i.hall_code);
      res_o.output_control = bldcdr_pkg::fwd_ctrl(tick_i.hall_code);
    end
  end

endmodule

// ===== rtl/bldc_duty_ramp_commutation.sv =====
// ----------------------------------------------------------------------------
// bldc_duty_ramp_commutation
// Two-axis PWM duty slew limiter with six-step commutation table select.
// ----------------------------------------------------------------------------
// Each input item is one timer tick for one axis and gives exactly one result
// item. The block takes one item per clock cycle. An accepted item is held in
// the input register and is then loaded into the result register, from which
// it leaves when the result side takes it. The per-axis duty, direction and
// hall fault state is updated as the result is loaded, so ticks for the same
// axis may follow each other in consecutive cycles. While the result side
// holds tready low the full registers stall; an empty input register still
// takes one item. Configuration writes take effect on the next tick and
// should be made while no item is in flight.
module bldc_duty_ramp_commutation #(
  parameter int DUTY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [bldcdr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bldcdr_pkg::CfgW-1:0]         cfg_data_i,
  // tick items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bldcdr_pkg::InW-1:0]          s_axis_tdata,  // req_duty, req_dir, hall_code
  input  logic                                s_axis_tuser,  // axis
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((DUTY_BITS + 3 + 2 * bldcdr_pkg::MaskW + 7) / 8) * 8 - 1:0]
                                              m_axis_tdata,  // duty, dir, flip,
                                                             // channel_mask, output_control,
                                                             // hall fault
  output logic                                m_axis_tuser   // out_axis
);

  localparam int OutBits = DUTY_BITS + 3 + 2 * bldcdr_pkg::MaskW;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  // configuration registers
  bldcdr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_floor <= bldcdr_pkg::MIN_DUTY_RST;
      cfg_q.duty_ceil  <= bldcdr_pkg::MAX_DUTY_RST;
      cfg_q.ramp_step  <= bldcdr_pkg::RAMP_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bldcdr_pkg::REG_MIN_DUTY:  cfg_q.duty_floor <= cfg_data_i;
        bldcdr_pkg::REG_MAX_DUTY:  cfg_q.duty_ceil  <= cfg_data_i;
        bldcdr_pkg::REG_RAMP_STEP: cfg_q.ramp_step  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  logic              in_valid_q, out_valid_q;
  logic              adv, upd;
  bldcdr_pkg::tick_t tick_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign upd           = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q.axis      <= s_axis_tuser;
      tick_q.req_duty  <= s_axis_tdata[bldcdr_pkg::CfgW-1:0];
      tick_q.req_dir   <= s_axis_tdata[bldcdr_pkg::CfgW];
      tick_q.hall_code <= s_axis_tdata[bldcdr_pkg::InBits-1:bldcdr_pkg::CfgW+1];
    end
  end

  // per-axis state
  logic signed [DUTY_BITS-1:0] duty_q [2];
  logic                        dir_q  [2];
  logic                        fault_q[2];

  logic signed [DUTY_BITS-1:0] new_duty;
  bldcdr_pkg::res_t            res;

  bldcdr_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .cur_duty_i  (duty_q[tick_q.axis]),
    .cur_dir_i   (dir_q[tick_q.axis]),
    .cur_fault_i (fault_q[tick_q.axis]),
    .tick_i      (tick_q),
    .cfg_i       (cfg_q),
    .new_duty_o  (new_duty),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        duty_q[i]  <= '0;
        dir_q[i]   <= 1'b0;
        fault_q[i] <= 1'b0;
      end
    end else if (upd) begin
      duty_q[tick_q.axis]  <= new_duty;
      dir_q[tick_q.axis]   <= res.dir;
      fault_q[tick_q.axis] <= res.fault;
    end
  end

  // result register
  logic                        out_axis_q;
  logic signed [DUTY_BITS-1:0] out_duty_q;
  bldcdr_pkg::res_t            out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_axis_q <= tick_q.axis;
      out_duty_q <= new_duty;
      out_res_q  <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_axis_q;
  assign m_axis_tdata  = {{(OutW-OutBits){1'b0}},
                          out_res_q.fault,
                          out_res_q.output_control,
                          out_res_q.channel_mask,
                          out_res_q.flip,
                          out_res_q.dir,
                          out_duty_q};

  // assertions
  a_upd_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> out_valid_q)
    else $error("tick processed without loading a result");

  a_flip_takes_req_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && res.flip) |=> (out_res_q.dir == $past(tick_q.req_dir)))
    else $error("reversal did not take the requested direction");

  a_fault0_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q[0] |=> fault_q[0])
    else $error("hall fault of axis 0 cleared");

  a_fault1_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q[1] |=> fault_q[1])
    else $error("hall fault of axis 1 cleared");

  a_no_flip_same_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && (tick_q.req_dir == dir_q[tick_q.axis])) |-> !res.flip)
    else $error("reversal without a direction change request");

endmodule
